[rtl/core/assert_macros.svh]
// Assertion macros used by the date converter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GJDC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold a fixed number of cycles after the antecedent.
`define GJDC_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

[rtl/core/gjdc_pkg.sv]
// Shared types, tables and helpers for the Gregorian/Jalali date converter.
`timescale 1ns / 1ps
`default_nettype none
package gjdc_pkg;

	typedef enum logic {
		CMD_G2J = 1'b0,
		CMD_J2G = 1'b1
	} cmd_t;

	localparam int QUAD_DAYS    = 1461;
	localparam int EPOCH_OFFSET = 226899;
	// 4 * epoch split into whole quad-year blocks and a remainder
	localparam int EPOCH_Q      = (4 * EPOCH_OFFSET) / QUAD_DAYS;
	localparam int EPOCH_R      = (4 * EPOCH_OFFSET) % QUAD_DAYS;
	localparam int G2J_YEAR_OFS = EPOCH_Q + 1;
	localparam int G2J_BIAS     = QUAD_DAYS - EPOCH_R;
	localparam int J2G_YEAR_OFS = EPOCH_Q;
	localparam int J2G_BIAS     = EPOCH_R + 1;

	typedef logic [8:0] cum_tbl_t [12];
	typedef logic [4:0] len_tbl_t [12];

	localparam cum_tbl_t GREG_CUM = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
	localparam cum_tbl_t GREG_CUM_LEAP = '{
		9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
		9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};
	localparam cum_tbl_t JAL_THR = '{
		9'd0, 9'd31, 9'd62, 9'd93, 9'd124, 9'd155,
		9'd186, 9'd216, 9'd246, 9'd276, 9'd306, 9'd336};
	localparam len_tbl_t GREG_LEN = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

	typedef struct packed {
		logic [12:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        err;
	} conv_t;

	typedef struct packed {
		logic [3:0] month;
		logic [4:0] day;
	} split_t;

	// Pick the month whose threshold lies just below d (d >= 1).
	function automatic split_t month_split(logic [8:0] d, cum_tbl_t tbl);
		split_t     r;
		logic [3:0] idx;
		idx = '0;
		for (int i = 1; i < 12; i++) begin
			if (d > tbl[i]) idx = 4'(i);
		end
		r.month = idx + 4'd1;
		r.day   = 5'(d - tbl[idx]);
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/gjdc_g2j.sv]
// Gregorian to Jalali conversion, combinational.
`timescale 1ns / 1ps
`default_nettype none
module gjdc_g2j (
	input  wire logic [11:0]   year,
	input  wire logic [3:0]    month,
	input  wire logic [4:0]    day,
	output gjdc_pkg::conv_t    res
);
	logic        month_ok;
	logic [3:0]  m_idx;
	logic        leap;
	logic [4:0]  len;
	logic        day_bad;
	logic [8:0]  cum;
	logic [8:0]  a;
	logic [1:0]  t;
	logic [11:0] v;
	logic        carry;
	logic [10:0] r;
	logic [10:0] r_inc;
	logic [8:0]  d0;
	logic [11:0] sa;
	logic [8:0]  d;
	logic        before_epoch;
	gjdc_pkg::split_t sp;

	always_comb begin
		month_ok = (month >= 4'd1) && (month <= 4'd12);
		m_idx    = month_ok ? (month - 4'd1) : 4'd0;
		leap     = (year[1:0] == 2'd0);
		len      = gjdc_pkg::GREG_LEN[m_idx] + {4'd0, (leap && (m_idx == 4'd1))};
		day_bad  = (day == 5'd0) || (day > len);
		cum      = leap ? gjdc_pkg::GREG_CUM_LEAP[m_idx] : gjdc_pkg::GREG_CUM[m_idx];
		a        = cum + {4'd0, day};
		t        = year[1:0] - 2'd1;
		// quarter-day remainder past the whole quad-year blocks
		v        = 12'(gjdc_pkg::G2J_BIAS) - {10'd0, t} + {1'b0, a, 2'b00};
		carry    = (v >= 12'(gjdc_pkg::QUAD_DAYS));
		r        = carry ? 11'(v - 12'(gjdc_pkg::QUAD_DAYS)) : v[10:0];
		r_inc    = r + 11'd1;
		d0       = r_inc[10:2];
		sa       = year - 12'(gjdc_pkg::G2J_YEAR_OFS) + {11'd0, carry};
		d        = d0 + {8'd0, (sa[1:0] == 2'd3)};
		before_epoch = (year < 12'(gjdc_pkg::G2J_YEAR_OFS)) ||
			((year == 12'(gjdc_pkg::G2J_YEAR_OFS)) && !carry);
		sp       = gjdc_pkg::month_split(d, gjdc_pkg::JAL_THR);

		res.err  = (year == 12'd0) || !month_ok || day_bad || before_epoch;
		if (d == 9'd0) begin
			res.year  = {1'b0, sa - 12'd1};
			res.month = 4'd12;
			res.day   = (sa[1:0] != 2'd0) ? 5'd29 : 5'd30;
		end else begin
			res.year  = {1'b0, sa};
			res.month = sp.month;
			res.day   = sp.day;
		end
		if (res.err) begin
			res.year  = '0;
			res.month = '0;
			res.day   = '0;
		end
	end
endmodule
`default_nettype wire

[rtl/core/gjdc_j2g.sv]
// Jalali to Gregorian conversion, combinational.
`timescale 1ns / 1ps
`default_nettype none
module gjdc_j2g (
	input  wire logic [11:0]   year,
	input  wire logic [3:0]    month,
	input  wire logic [4:0]    day,
	output gjdc_pkg::conv_t    res
);
	logic        month_ok;
	logic [3:0]  m_idx;
	logic [4:0]  lim;
	logic        day_bad;
	logic [8:0]  a;
	logic [10:0] w;
	logic        carry;
	logic [10:0] rr;
	logic [12:0] sa;
	logic [12:0] sa_m1;
	logic [10:0] q;
	logic [8:0]  d;
	gjdc_pkg::split_t sp_leap;
	gjdc_pkg::split_t sp_norm;

	always_comb begin
		month_ok = (month >= 4'd1) && (month <= 4'd12);
		m_idx    = month_ok ? (month - 4'd1) : 4'd0;
		lim      = (month <= 4'd6) ? 5'd31 : 5'd30;
		day_bad  = (day == 5'd0) || (day > lim);
		a        = gjdc_pkg::JAL_THR[m_idx] + {4'd0, day};
		// quarter-day remainder past the whole quad-year blocks
		w        = 11'(gjdc_pkg::J2G_BIAS) - {9'd0, year[1:0]} + {a, 2'b00};
		carry    = (w >= 11'(gjdc_pkg::QUAD_DAYS));
		rr       = carry ? (w - 11'(gjdc_pkg::QUAD_DAYS)) : w;
		sa       = {1'b0, year} + 13'(gjdc_pkg::J2G_YEAR_OFS) + {12'd0, carry};
		sa_m1    = sa - 13'd1;
		q        = rr + {9'd0, sa_m1[1:0]};
		d        = q[10:2];
		sp_leap  = gjdc_pkg::month_split(d, gjdc_pkg::GREG_CUM_LEAP);
		sp_norm  = gjdc_pkg::month_split(d, gjdc_pkg::GREG_CUM);

		res.err  = (year == 12'd0) || !month_ok || day_bad;
		if (d == 9'd0) begin
			res.year  = sa_m1;
			res.month = 4'd12;
			res.day   = 5'd31;
		end else if (sa[1:0] == 2'd0) begin
			res.year  = sa;
			res.month = sp_leap.month;
			res.day   = sp_leap.day;
		end else if (d < 9'd366) begin
			res.year  = sa;
			res.month = sp_norm.month;
			res.day   = sp_norm.day;
		end else begin
			res.year  = sa + 13'd1;
			res.month = 4'd1;
			res.day   = 5'd1;
		end
		if (res.err) begin
			res.year  = '0;
			res.month = '0;
			res.day   = '0;
		end
	end
endmodule
`default_nettype wire

[rtl/core/gregorian_jalali_date_converter_core.sv]
// Top level of the Gregorian/Jalali date converter.
//
// Usage:
//   Drive command, in_year, in_month and in_day and raise start for one
//   cycle per date; a beat is taken at every clock edge where start is high
//   and busy is low. busy stays low: a new date may enter in every cycle.
//   command selects Gregorian to Jalali (CMD_G2J) or the reverse (CMD_J2G).
//
//   Each input beat yields exactly one result beat. done is high for one
//   cycle while out_year, out_month, out_day and range_error carry it.
//   An accepted date passes through the input register, then the result
//   register. Throughput: one date per cycle, set by the single
//   register-to-register conversion pass.
//
//   range_error flags a bad month or day, year zero, or a Gregorian date
//   before the Jalali epoch; the date outputs then read zero.
//
//   Reset (arst_n low) drops any date in flight and clears done. The
//   receiver has no way to stall: grab each result while done is high.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gregorian_jalali_date_converter_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic        command,
	input  wire logic [11:0] in_year,
	input  wire logic [3:0]  in_month,
	input  wire logic [4:0]  in_day,
	output      logic        done,
	output      logic [12:0] out_year,
	output      logic [3:0]  out_month,
	output      logic [4:0]  out_day,
	output      logic        range_error
);
	// input stage
	logic                 valid_s1;
	gjdc_pkg::cmd_t       cmd_s1;
	logic [11:0]          year_s1;
	logic [3:0]           month_s1;
	logic [4:0]           day_s1;

	gjdc_pkg::conv_t      g2j_res;
	gjdc_pkg::conv_t      j2g_res;
	gjdc_pkg::conv_t      sel_res;

	logic                 accept;

	// Every cycle is open for a new beat.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Hold the payload when no beat arrives.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= gjdc_pkg::cmd_t'(command);
			year_s1  <= in_year;
			month_s1 <= in_month;
			day_s1   <= in_day;
		end
	end

	// Both directions run in parallel; the command picks one.
	gjdc_g2j u_g2j (
		.year  (year_s1),
		.month (month_s1),
		.day   (day_s1),
		.res   (g2j_res)
	);

	gjdc_j2g u_j2g (
		.year  (year_s1),
		.month (month_s1),
		.day   (day_s1),
		.res   (j2g_res)
	);

	always_comb begin
		case (cmd_s1)
			gjdc_pkg::CMD_G2J: sel_res = g2j_res;
			gjdc_pkg::CMD_J2G: sel_res = j2g_res;
			default:           sel_res = g2j_res;
		endcase
	end

	// Result register: the strobe is cleared by reset, the payload is not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			out_year    <= sel_res.year;
			out_month   <= sel_res.month;
			out_day     <= sel_res.day;
			range_error <= sel_res.err;
		end
	end

	`GJDC_ASSERT_DELAY(a_latency, accept, 2, done, "accepted beat did not produce a result")
	`GJDC_ASSERT_SAME(a_no_orphan, done, $past(valid_s1), "result without an input beat")
	`GJDC_ASSERT_SAME(a_err_zero, done && range_error,
		(out_year == 13'd0) && (out_month == 4'd0) && (out_day == 5'd0),
		"rejected date has nonzero outputs")
	`GJDC_ASSERT_SAME(a_ok_range, done && !range_error,
		(out_month >= 4'd1) && (out_month <= 4'd12) && (out_day >= 5'd1),
		"converted date out of range")

endmodule
`default_nettype wire
